FILE: rtl/core/rmv_pkg.sv
// rmv_pkg: widths, engine request type and row accumulator type shared by
// the row mean and variance block. No dependencies.
package rmv_pkg;

  localparam int unsigned ROW_MAX = 1024;
  localparam int unsigned LEN_W   = 11;
  localparam int unsigned SMP_W   = 16;
  localparam int unsigned SUM_W   = 26;
  localparam int unsigned SQ_W    = 41;
  localparam int unsigned ENG_W   = 51;
  localparam int unsigned STEP_W  = 6;
  localparam int unsigned AVG_W   = 16;
  localparam int unsigned VAR_W   = 31;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } eng_op_e;

  typedef struct packed {
    logic              start;
    eng_op_e           op;
    logic [ENG_W-1:0]  opa;
    logic [ENG_W-1:0]  opb;
    logic [STEP_W-1:0] steps;
  } eng_req_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         sq;
    logic [LEN_W-1:0]        cnt;
  } row_acc_t;

endpackage

FILE: rtl/core/rmv_if.sv
// rmv_if: valid/ready channel interfaces for samples in and row results out.
// Depends on rmv_pkg for the field widths.
interface rmv_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [rmv_pkg::SMP_W-1:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface rmv_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [rmv_pkg::AVG_W-1:0]  row_average;
  logic [rmv_pkg::VAR_W-1:0]         row_spread;

  modport source (output valid, output row_average, output row_spread, input ready);
  modport sink (input valid, input row_average, input row_spread, output ready);
endinterface

FILE: rtl/core/row_mean_variance.sv
// row_mean_variance: top level, sequencer and output register.
// Depends on rmv_pkg, rmv_if, rmv_accum and rmv_engine.
//
// Per-row mean (Q8.8, truncated toward zero) and population variance
// (Q16.16, truncated) of signed Q8.8 samples. Input ready is high in S_IDLE,
// so a sample that does not close a row is taken without a stall. The sample
// that closes a row holds the input until the earliest next request: the one
// shared 52-bit adder runs n*Q (11 steps), S*S (26 steps) and n*n (11 steps)
// as shift-add multiplies, then the variance and mean as 51-step restoring
// divides, sequenced by the state machine from S_PREP through S_DONE. The
// finished result sits in an output register, so the next row is accepted
// while it waits to be taken; a following result waits only if that register
// is still full. The row length register is written through
// cfg_we_i/cfg_wdata_i; 0 acts as 1 and values above 1024 act as 1024.
module row_mean_variance (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [rmv_pkg::LEN_W-1:0] cfg_wdata_i,
  rmv_in_if.sink                    in_i,
  rmv_out_if.source                 out_o
);
  import rmv_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_PREP = 8'b0000_0010,
    S_NQ   = 8'b0000_0100,
    S_SS   = 8'b0000_1000,
    S_NN   = 8'b0001_0000,
    S_VAR  = 8'b0010_0000,
    S_MEAN = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_e;

  state_e                   state_q, state_d;
  row_acc_t                 acc;
  logic                     last;
  logic                     take;
  logic                     clear;
  eng_req_t                 eng_req;
  logic [ENG_W-1:0]         eng_res;
  logic                     eng_done;
  logic                     eng_busy;
  logic [SUM_W-1:0]         mag;
  logic [AVG_W-1:0]         quot;
  logic [ENG_W-1:0]         nq_q, nq_d;
  logic [ENG_W-1:0]         num_q, num_d;
  logic [VAR_W-1:0]         var_q, var_d;
  logic signed [AVG_W-1:0]  mean_q, mean_d;
  logic                     out_valid_q, out_valid_d;
  logic signed [AVG_W-1:0]  out_avg_q;
  logic [VAR_W-1:0]         out_var_q;
  logic                     out_load;

  assign in_i.ready = (state_q == S_IDLE);
  assign take       = in_i.valid & in_i.ready;

  rmv_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .take_i      (take),
    .sample_i    (in_i.sample),
    .clear_i     (clear),
    .acc_o       (acc),
    .last_o      (last)
  );

  rmv_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (eng_req),
    .res_o  (eng_res),
    .done_o (eng_done),
    .busy_o (eng_busy)
  );

  assign mag  = acc.sum[SUM_W-1] ? SUM_W'(-acc.sum) : SUM_W'(acc.sum);
  assign quot = eng_res[AVG_W-1:0];

  always_comb begin
    state_d       = state_q;
    nq_d          = nq_q;
    num_d         = num_q;
    var_d         = var_q;
    mean_d        = mean_q;
    clear         = 1'b0;
    out_load      = 1'b0;
    eng_req       = '0;
    eng_req.op    = OP_MUL;
    case (state_q)
      S_IDLE: begin
        if (take && last) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        eng_req.start = 1'b1;
        eng_req.opa   = ENG_W'(acc.sq);
        eng_req.opb   = ENG_W'(acc.cnt);
        eng_req.steps = STEP_W'(LEN_W);
        state_d       = S_NQ;
      end
      S_NQ: begin
        if (eng_done) begin
          nq_d          = eng_res;
          eng_req.start = 1'b1;
          eng_req.opa   = ENG_W'(mag);
          eng_req.opb   = ENG_W'(mag);
          eng_req.steps = STEP_W'(SUM_W);
          state_d       = S_SS;
        end
      end
      S_SS: begin
        if (eng_done) begin
          num_d         = nq_q - eng_res;
          eng_req.start = 1'b1;
          eng_req.opa   = ENG_W'(acc.cnt);
          eng_req.opb   = ENG_W'(acc.cnt);
          eng_req.steps = STEP_W'(LEN_W);
          state_d       = S_NN;
        end
      end
      S_NN: begin
        if (eng_done) begin
          eng_req.start = 1'b1;
          eng_req.op    = OP_DIV;
          eng_req.opa   = num_q;
          eng_req.opb   = eng_res;
          eng_req.steps = STEP_W'(ENG_W);
          state_d       = S_VAR;
        end
      end
      S_VAR: begin
        if (eng_done) begin
          var_d         = eng_res[VAR_W-1:0];
          eng_req.start = 1'b1;
          eng_req.op    = OP_DIV;
          eng_req.opa   = ENG_W'(mag);
          eng_req.opb   = ENG_W'(acc.cnt);
          eng_req.steps = STEP_W'(ENG_W);
          state_d       = S_MEAN;
        end
      end
      S_MEAN: begin
        if (eng_done) begin
          // truncation toward zero: divide the magnitude, then restore sign
          mean_d  = acc.sum[SUM_W-1] ? signed'(-quot) : signed'(quot);
          clear   = 1'b1;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nq_q   <= nq_d;
    num_q  <= num_d;
    var_q  <= var_d;
    mean_q <= mean_d;
    if (out_load) begin
      out_avg_q <= mean_q;
      out_var_q <= var_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.row_average = out_avg_q;
  assign out_o.row_spread  = out_var_q;

  // no sample request is taken while the shared unit is running
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_busy |-> !in_i.ready)
    else $error("sample ready while engine busy");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside done state");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc.cnt <= LEN_W'(ROW_MAX))
    else $error("element count beyond row maximum");

  a_row_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MEAN && eng_done) |=> (acc.cnt == '0 && acc.sum == '0))
    else $error("accumulators not cleared after row");

endmodule

FILE: rtl/core/rmv_accum.sv
// rmv_accum: row length register, running sum, sum of squares and element
// count, with end-of-row detection. Depends on rmv_pkg.
module rmv_accum (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rmv_pkg::LEN_W-1:0]         cfg_wdata_i,
  input  logic                              take_i,
  input  logic signed [rmv_pkg::SMP_W-1:0]  sample_i,
  input  logic                              clear_i,
  output rmv_pkg::row_acc_t                 acc_o,
  output logic                              last_o
);
  import rmv_pkg::*;

  logic [LEN_W-1:0]         row_length_q;
  logic [LEN_W-1:0]         eff_len;
  logic [LEN_W-1:0]         cnt_inc;
  logic signed [2*SMP_W-1:0] sq_prod;
  row_acc_t                 acc_q, acc_d;

  always_comb begin
    eff_len = row_length_q;
    if (row_length_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (row_length_q > LEN_W'(ROW_MAX)) begin
      eff_len = LEN_W'(ROW_MAX);
    end
  end

  // last marks the sample whose count reaches or passes the effective row length
  assign cnt_inc = acc_q.cnt + LEN_W'(1);
  assign last_o  = (cnt_inc >= eff_len);
  assign sq_prod = sample_i * sample_i;

  always_comb begin
    acc_d = acc_q;
    if (clear_i) begin
      acc_d = '0;
    end else if (take_i) begin
      acc_d.sum = acc_q.sum + SUM_W'(sample_i);
      acc_d.sq  = acc_q.sq + SQ_W'(unsigned'(sq_prod));
      acc_d.cnt = cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q        <= '0;
      row_length_q <= LEN_W'(1);
    end else begin
      acc_q <= acc_d;
      if (cfg_we_i) begin
        row_length_q <= cfg_wdata_i;
      end
    end
  end

  assign acc_o = acc_q;

endmodule

FILE: rtl/core/rmv_engine.sv
// rmv_engine: shared shift-add multiplier and restoring divider around one
// adder/subtractor, one bit per cycle. Depends on rmv_pkg.
module rmv_engine (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rmv_pkg::eng_req_t         req_i,
  output logic [rmv_pkg::ENG_W-1:0] res_o,
  output logic                      done_o,
  output logic                      busy_o
);
  import rmv_pkg::*;

  eng_op_e           op_q, op_d;
  logic [ENG_W-1:0]  acc_q, acc_d;
  logic [ENG_W-1:0]  opa_q, opa_d;
  logic [ENG_W-1:0]  opb_q, opb_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [ENG_W:0]    rem_shift;
  logic [ENG_W:0]    add_x, add_y;
  logic              sub;
  logic [ENG_W+1:0]  add_sum;
  logic              carry;

  // multiply: acc += opa when opb lsb set; divide: acc is the remainder,
  // opa shifts the dividend out and the quotient in
  assign rem_shift = {acc_q, opa_q[ENG_W-1]};
  assign sub       = (op_q == OP_DIV);
  assign add_x     = sub ? rem_shift : {1'b0, acc_q};
  assign add_y     = sub ? {1'b0, opb_q} : {1'b0, opa_q};
  assign add_sum   = {1'b0, add_x} + {1'b0, add_y ^ {(ENG_W+1){sub}}}
                     + (ENG_W+2)'(sub);
  assign carry     = add_sum[ENG_W+1];

  always_comb begin
    op_d   = op_q;
    acc_d  = acc_q;
    opa_d  = opa_q;
    opb_d  = opb_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (busy_q) begin
      case (op_q)
        OP_MUL: begin
          if (opb_q[0]) begin
            acc_d = add_sum[ENG_W-1:0];
          end
          opa_d = {opa_q[ENG_W-2:0], 1'b0};
          opb_d = {1'b0, opb_q[ENG_W-1:1]};
        end
        OP_DIV: begin
          // carry out of the subtract means no borrow
          acc_d = carry ? add_sum[ENG_W-1:0] : rem_shift[ENG_W-1:0];
          opa_d = {opa_q[ENG_W-2:0], carry};
        end
        default: begin
          acc_d = acc_q;
        end
      endcase
      cnt_d = cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      op_d   = req_i.op;
      acc_d  = '0;
      opa_d  = req_i.opa;
      opb_d  = req_i.opb;
      cnt_d  = req_i.steps;
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OP_MUL;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    opa_q <= opa_d;
    opb_q <= opb_d;
  end

  assign res_o  = (op_q == OP_DIV) ? opa_q : acc_q;
  assign done_o = done_q;
  assign busy_o = busy_q;

endmodule
